>>> sv/lidar_point_frustum_crop_macros.svh
// Assertion macros for the lidar point frustum crop block.
// Used by lidar_point_frustum_crop; no other dependencies.
`ifndef LIDAR_POINT_FRUSTUM_CROP_MACROS_SVH
`define LIDAR_POINT_FRUSTUM_CROP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define LPFC_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lpfc check failed");
// next-cycle implication checked outside reset
`define LPFC_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lpfc check failed");
`endif

>>> sv/lpfc_pkg.sv
// Types and constants for the lidar point frustum crop block.
// No dependencies.
package lpfc_pkg;
    localparam int WORD_BITS = 32;
    localparam int PIX_BITS  = 16;
    localparam int NUM_REGS  = 8;
    localparam int IDX_BITS  = 3;
    localparam int SUM_BITS  = 128;
    localparam int DIV_STEPS = 16;

    localparam logic [IDX_BITS-1:0] REG_ROW0_A      = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ROW2_B      = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_IMAGE_SIZE  = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_CROP_ENABLE = 3'd7;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] point_x;
        logic signed [WORD_BITS-1:0] point_y;
        logic signed [WORD_BITS-1:0] point_z;
        logic [15:0]                 reflectance;
    } point_in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] out_x;
        logic signed [WORD_BITS-1:0] out_y;
        logic signed [WORD_BITS-1:0] out_z;
        logic [15:0]                 out_reflectance;
        logic [PIX_BITS-1:0]         pixel_column;
        logic [PIX_BITS-1:0]         pixel_row;
    } point_out_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] index;
        logic [63:0]         data;
    } cfg_req_t;

    // per-cell control that travels with the point down the chain
    typedef struct packed {
        logic valid;
        logic keep;
        logic crop;
    } lpfc_ctl_t;

    // one quotient being resolved bit by bit
    typedef struct packed {
        logic [SUM_BITS-1:0] rem;
        logic [SUM_BITS-1:0] den;
        logic [PIX_BITS-1:0] quot;
    } lpfc_div_t;
endpackage

>>> sv/lidar_point_frustum_crop.sv
// Lidar point frustum crop: points pass the projection front end, the division chain and the output register.
// Throughput one point per cycle; the chain of 16 division cells stalls as a
// whole only when the output register is full and not taken.
// Asynchronous active-low reset clears valid flags and sets registers to reset
// values (matrix and image size zero, cropping enabled).
// Depends on lpfc_pkg, lpfc_proj, lpfc_div_cell and the macros header.
module lidar_point_frustum_crop #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lpfc_pkg::point_in_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lpfc_pkg::point_out_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  lpfc_pkg::cfg_req_t   cfg_data
);
    import lpfc_pkg::*;
    `include "lidar_point_frustum_crop_macros.svh"

    logic [63:0] mat_reg [6];
    logic [31:0] size_reg;
    logic        crop_reg;
    logic        advance;
    logic        out_valid_reg;
    logic        in_view;
    point_out_t  out_reg;

    lpfc_ctl_t ctl [DIV_STEPS+1];
    lpfc_div_t col [DIV_STEPS+1];
    lpfc_div_t row [DIV_STEPS+1];
    point_in_t pt  [DIV_STEPS+1];

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                mat_reg[i] <= '0;
            end
            size_reg <= '0;
            crop_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_data.index <= REG_ROW2_B)
            begin
                mat_reg[cfg_data.index] <= cfg_data.data;
            end
            else if (cfg_data.index == REG_IMAGE_SIZE)
            begin
                size_reg <= cfg_data.data[31:0];
            end
            else if (cfg_data.index == REG_CROP_ENABLE)
            begin
                crop_reg <= cfg_data.data[0];
            end
        end
    end

    lpfc_proj #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_proj (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid),
        .pt_in       (in_data),
        .mat         (mat_reg),
        .crop_enable (crop_reg),
        .ctl_out     (ctl[0]),
        .col_out     (col[0]),
        .row_out     (row[0]),
        .pt_out      (pt[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_cell
        lpfc_div_cell #(.BIT_POS(DIV_STEPS-1-g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ctl_in  (ctl[g]),
            .col_in  (col[g]),
            .row_in  (row[g]),
            .pt_in   (pt[g]),
            .ctl_out (ctl[g+1]),
            .col_out (col[g+1]),
            .row_out (row[g+1]),
            .pt_out  (pt[g+1])
        );
    end

    assign in_view = (col[DIV_STEPS].quot < size_reg[15:0])
                  && (row[DIV_STEPS].quot < size_reg[31:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ctl[DIV_STEPS].valid && ctl[DIV_STEPS].keep
                && (!ctl[DIV_STEPS].crop || in_view);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_x <= COORD_BITS >= WORD_BITS ? pt[DIV_STEPS].point_x
                : WORD_BITS'(pt[DIV_STEPS].point_x[COORD_BITS-1:0]);
            out_reg.out_y <= COORD_BITS >= WORD_BITS ? pt[DIV_STEPS].point_y
                : WORD_BITS'(pt[DIV_STEPS].point_y[COORD_BITS-1:0]);
            out_reg.out_z <= COORD_BITS >= WORD_BITS ? pt[DIV_STEPS].point_z
                : WORD_BITS'(pt[DIV_STEPS].point_z[COORD_BITS-1:0]);
            out_reg.out_reflectance <= pt[DIV_STEPS].reflectance;
            out_reg.pixel_column <= ctl[DIV_STEPS].crop ? col[DIV_STEPS].quot : '0;
            out_reg.pixel_row    <= ctl[DIV_STEPS].crop ? row[DIV_STEPS].quot : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `LPFC_ASSERT_IMP(a_stall_ready, clk, rst_n, out_valid_reg && !out_ready, !in_ready)
    `LPFC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg)
    `LPFC_ASSERT_NEXT(a_nocrop_zero, clk, rst_n,
        advance && ctl[DIV_STEPS].valid && !ctl[DIV_STEPS].crop,
        out_reg.pixel_column == '0 && out_reg.pixel_row == '0)
endmodule

>>> sv/lpfc_div_cell.sv
// One restoring division cell: resolves one quotient bit of column and row.
// Depends on lpfc_pkg.
module lpfc_div_cell #(
    parameter int BIT_POS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  lpfc_pkg::lpfc_ctl_t ctl_in,
    input  lpfc_pkg::lpfc_div_t col_in,
    input  lpfc_pkg::lpfc_div_t row_in,
    input  lpfc_pkg::point_in_t pt_in,
    output lpfc_pkg::lpfc_ctl_t ctl_out,
    output lpfc_pkg::lpfc_div_t col_out,
    output lpfc_pkg::lpfc_div_t row_out,
    output lpfc_pkg::point_in_t pt_out
);
    import lpfc_pkg::*;

    lpfc_ctl_t ctl_reg;
    lpfc_div_t col_reg, col_next, row_reg, row_next;
    point_in_t pt_reg;
    logic [SUM_BITS-1:0] col_try, row_try;

    always_comb
    begin
        col_try  = col_in.den << BIT_POS;
        row_try  = row_in.den << BIT_POS;
        col_next = col_in;
        row_next = row_in;
        if (col_in.rem >= col_try)
        begin
            col_next.rem = col_in.rem - col_try;
            col_next.quot[BIT_POS] = 1'b1;
        end
        if (row_in.rem >= row_try)
        begin
            row_next.rem = row_in.rem - row_try;
            row_next.quot[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            pt_reg  <= pt_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign col_out = col_reg;
    assign row_out = row_reg;
    assign pt_out  = pt_reg;
endmodule

>>> sv/lpfc_proj.sv
// Projection front end: products, row sums, sign and range screening.
// Depends on lpfc_pkg.
module lpfc_proj #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  lpfc_pkg::point_in_t pt_in,
    input  logic [63:0]         mat [6],
    input  logic                crop_enable,
    output lpfc_pkg::lpfc_ctl_t ctl_out,
    output lpfc_pkg::lpfc_div_t col_out,
    output lpfc_pkg::lpfc_div_t row_out,
    output lpfc_pkg::point_in_t pt_out
);
    import lpfc_pkg::*;

    localparam int PROD_BITS = COORD_BITS + WORD_BITS + 1;

    logic signed [COORD_BITS:0]   coord [4];
    logic signed [WORD_BITS-1:0]  coef  [12];
    logic signed [PROD_BITS-1:0]  prod_reg [12];
    logic signed [SUM_BITS-1:0]   sum [3];
    logic signed [SUM_BITS-1:0]   sum_reg [3];
    lpfc_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    point_in_t pt1_reg, pt2_reg, pt3_reg;
    logic [SUM_BITS-1:0] a0, a1, b, a0_reg, a1_reg, b_reg;
    logic ok1, ok2, ok2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            coord[i] = '0;
        end
        coord[0] = {pt_in.point_x[COORD_BITS-1], pt_in.point_x[COORD_BITS-1:0]};
        coord[1] = {pt_in.point_y[COORD_BITS-1], pt_in.point_y[COORD_BITS-1:0]};
        coord[2] = {pt_in.point_z[COORD_BITS-1], pt_in.point_z[COORD_BITS-1:0]};
        coord[3] = (COORD_BITS+1)'(1) <<< FRAC_BITS;
        for (int k = 0; k < 12; k++)
        begin
            coef[k] = mat[k/2][32*(k%2) +: WORD_BITS];
        end
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = '0;
            for (int c = 0; c < 4; c++)
            begin
                sum[r] = sum[r] + SUM_BITS'(prod_reg[r*4+c]);
            end
        end
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r*4+c] <= PROD_BITS'(coef[r*4+c] * coord[c]);
                end
            end
            pt1_reg <= pt_in;
        end
    end

    // stage 2: sums
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= sum[r];
            end
            pt2_reg <= pt1_reg;
        end
    end

    // stage 3: signs, magnitudes
    always_comb
    begin
        a0  = sum_reg[0][SUM_BITS-1] ? -sum_reg[0] : sum_reg[0];
        a1  = sum_reg[1][SUM_BITS-1] ? -sum_reg[1] : sum_reg[1];
        b   = sum_reg[2][SUM_BITS-1] ? -sum_reg[2] : sum_reg[2];
        ok1 = (sum_reg[2] != '0)
            && ((sum_reg[0] == '0) || (sum_reg[0][SUM_BITS-1] == sum_reg[2][SUM_BITS-1]))
            && ((sum_reg[1] == '0) || (sum_reg[1][SUM_BITS-1] == sum_reg[2][SUM_BITS-1]));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a0_reg  <= a0;
            a1_reg  <= a1;
            b_reg   <= b;
            ok2_reg <= ok1;
            pt3_reg <= pt2_reg;
        end
    end

    // after stage 3, combinational: drop quotients that do not fit the pixel width
    assign ok2 = ok2_reg && (a0_reg < (b_reg << PIX_BITS))
               && (a1_reg < (b_reg << PIX_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (advance)
        begin
            ctl1_reg.valid <= in_valid;
            ctl1_reg.crop  <= crop_enable;
            ctl1_reg.keep  <= !(crop_enable && coord[0][COORD_BITS]);
            ctl2_reg       <= ctl1_reg;
            ctl3_reg       <= ctl2_reg;
        end
    end

    assign ctl_out.valid = ctl3_reg.valid;
    assign ctl_out.crop  = ctl3_reg.crop;
    assign ctl_out.keep  = ctl3_reg.keep && (!ctl3_reg.crop || ok2);
    assign col_out = '{rem: a0_reg, den: b_reg, quot: '0};
    assign row_out = '{rem: a1_reg, den: b_reg, quot: '0};
    assign pt_out  = pt3_reg;
endmodule

>>> bench/tb_lidar_point_frustum_crop.sv
// Self-checking bench for the lidar point frustum crop block: drives points and register
// writes through valid/ready channels and compares each kept point with a bit-exact predictor.
// Depends on lpfc_pkg and the lidar_point_frustum_crop RTL.
module tb_lidar_point_frustum_crop;
    import lpfc_pkg::*;

    localparam int LATENCY   = 20;
    localparam int MAX_CYCLE = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    point_in_t  in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    point_out_t out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_req_t   cfg_data = '0;

    logic [63:0] mat_q [6];
    logic [31:0] size_q;
    logic        crop_q;

    point_in_t  pending_points [$];
    point_out_t kept_points [$];
    int         mismatches = 0;
    int         kept_total = 0;
    int         sent_total = 0;
    int         cycle = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    bit         calm = 1'b0;
    int         hold_recv = 0;
    bit         gate_send = 1'b0;
    bit         in_taken = 1'b0;

    lidar_point_frustum_crop uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic signed [127:0] row_sum(int r, point_in_t p);
        logic signed [127:0] acc;
        logic signed [31:0]  c;
        logic signed [127:0] v [4];
        acc = '0;
        v[0] = p.point_x;
        v[1] = p.point_y;
        v[2] = p.point_z;
        v[3] = 128'sd65536;
        for (int k = 0; k < 4; k++)
        begin
            c = mat_q[r*2 + k/2][32*(k%2) +: 32];
            acc = acc + 128'(c) * v[k];
        end
        return acc;
    endfunction

    function automatic bit ratio_ok(logic signed [127:0] num, logic signed [127:0] den,
                                    logic [15:0] bound, output logic [15:0] q);
        logic [127:0] a, b;
        logic [127:0] quo;
        q = '0;
        if (den == 0)
            return 1'b0;
        if (num != 0 && (num[127] != den[127]))
            return 1'b0;
        a = num[127] ? -num : num;
        b = den[127] ? -den : den;
        quo = a / b;
        if (quo >= {112'd0, bound})
            return 1'b0;
        q = quo[15:0];
        return 1'b1;
    endfunction

    function automatic bit project_point(point_in_t p, output point_out_t o);
        logic [15:0] col, row;
        logic signed [127:0] s0, s1, s2;
        col = '0;
        row = '0;
        o = '0;
        if (crop_q)
        begin
            if (p.point_x[31])
                return 1'b0;
            s0 = row_sum(0, p);
            s1 = row_sum(1, p);
            s2 = row_sum(2, p);
            if (!ratio_ok(s0, s2, size_q[15:0], col))
                return 1'b0;
            if (!ratio_ok(s1, s2, size_q[31:16], row))
                return 1'b0;
        end
        o.out_x = p.point_x;
        o.out_y = p.point_y;
        o.out_z = p.point_z;
        o.out_reflectance = p.reflectance;
        o.pixel_column = col;
        o.pixel_row = row;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle);
        mismatches++;
    endtask

    task automatic add_point(point_in_t p);
        pending_points.insert(pending_points.size(), p);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken && !calm && $urandom_range(0, 15) == 0)
                send_gap = $urandom_range(1, 9);
            if (!in_valid || in_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_points.size() > 0 && !gate_send)
                begin
                    in_data <= pending_points.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_recv > 0)
            begin
                hold_recv--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (!calm && $urandom_range(0, 15) == 0)
                    recv_gap = $urandom_range(1, 9);
                out_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycle++;
        if (cycle > MAX_CYCLE)
        begin
            $display("timeout at cycle %0d", cycle);
            $display("[lidar_point_frustum_crop] ERROR");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (kept_points.size() == 0)
                report_mismatch("unexpected point", out_data.out_x, 0);
            else
            begin
                point_out_t e;
                e = kept_points.pop_front();
                kept_total++;
                if (out_data.out_x !== e.out_x)
                    report_mismatch("out_x", out_data.out_x, e.out_x);
                if (out_data.out_y !== e.out_y)
                    report_mismatch("out_y", out_data.out_y, e.out_y);
                if (out_data.out_z !== e.out_z)
                    report_mismatch("out_z", out_data.out_z, e.out_z);
                if (out_data.out_reflectance !== e.out_reflectance)
                    report_mismatch("out_reflectance", out_data.out_reflectance,
                                    e.out_reflectance);
                if (out_data.pixel_column !== e.pixel_column)
                    report_mismatch("pixel_column", out_data.pixel_column, e.pixel_column);
                if (out_data.pixel_row !== e.pixel_row)
                    report_mismatch("pixel_row", out_data.pixel_row, e.pixel_row);
            end
        end
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
        begin
            point_out_t o;
            if (project_point(in_data, o))
                kept_points.insert(kept_points.size(), o);
            sent_total++;
        end
    end

    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_data.index <= idx;
        cfg_data.data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < REG_IMAGE_SIZE)
            mat_q[idx] = val;
        else if (idx == REG_IMAGE_SIZE)
            size_q = val[31:0];
        else
            crop_q = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_all();
        while (pending_points.size() > 0 || in_valid || kept_points.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);
    endtask

    function automatic logic [31:0] coef(int pix);
        return 32'(pix) <<< 16;
    endfunction

    // a camera looking down +x: column ~ f*(-y)/x + cx, row ~ f*(-z)/x + cy
    task automatic load_camera(int f, int cx, int cy, int w, int h);
        write_reg(REG_ROW0_A, {coef(-f), coef(cx)});
        write_reg(IDX_BITS'(REG_ROW0_A + 1), {32'd0, 32'd0});
        write_reg(IDX_BITS'(REG_ROW0_A + 2), {32'd0, coef(cy)});
        write_reg(IDX_BITS'(REG_ROW0_A + 3), {32'd0, coef(-f)});
        write_reg(IDX_BITS'(REG_ROW0_A + 4), {32'd0, 32'h0001_0000});
        write_reg(REG_ROW2_B, 64'd0);
        write_reg(REG_IMAGE_SIZE, {32'd0, 16'(h), 16'(w)});
    endtask

    function automatic point_in_t rand_point(int mode);
        point_in_t p;
        p.reflectance = 16'($urandom);
        if (mode == 0)
        begin
            p.point_x = $urandom;
            p.point_y = $urandom;
            p.point_z = $urandom;
        end
        else
        begin
            p.point_x = 32'($urandom_range(1, 60)) << 16 | 32'($urandom_range(0, 65535));
            p.point_y = $signed(32'($urandom_range(0, 40 << 16))) - (20 << 16);
            p.point_z = $signed(32'($urandom_range(0, 16 << 16))) - (8 << 16);
        end
        return p;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            add_point(rand_point($urandom_range(0, 9) < 7));
    endtask

    initial
    begin
        point_in_t p;
        for (int i = 0; i < 6; i++)
            mat_q[i] = '0;
        size_q = '0;
        crop_q = 1'b1;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset matrix: zero depth drops everything, then pass-through
        p = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 16'hffff};
        add_point(p);
        drain_all();
        write_reg(REG_CROP_ENABLE, 64'hffff_fffe);
        write_reg(REG_CROP_ENABLE, 64'd1);
        write_reg(REG_CROP_ENABLE, 64'd0);
        add_point('{32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff, 16'h0});
        add_point('{32'sh7fff_ffff, 32'sh0, 32'sh8000_0000, 16'hffff});
        add_point('{32'sh0, 32'shffff_ffff, 32'sh7fff_ffff, 16'h5a5a});
        drain_all();

        // directed crop cases
        write_reg(REG_CROP_ENABLE, 64'd1);
        load_camera(100, 320, 240, 640, 480);
        add_point('{32'sh000a_0000, 32'sh0, 32'sh0, 16'h1234});
        add_point('{-32'sh000a_0000, 32'sh0, 32'sh0, 16'h1});
        add_point('{32'sh0, 32'sh0, 32'sh0, 16'h2});
        add_point('{32'sh000a_0000, 32'sh0020_0000, 32'sh0, 16'h3});
        add_point('{32'sh000a_0000, -32'sh0020_0000, 32'sh0, 16'h4});
        add_point('{32'sh000a_0000, 32'sh0020_0001, 32'sh0, 16'h5});
        add_point('{32'sh000a_0000, 32'sh0, 32'sh0018_0000, 16'h6});
        add_point('{32'sh000a_0000, 32'sh0, -32'sh0018_0000, 16'h7});
        add_point('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 16'h8});
        drain_all();
        write_reg(REG_IMAGE_SIZE, 64'hffff_ffff_0000_01e0);
        add_point('{32'sh000a_0000, 32'sh0, 32'sh0, 16'h9});
        drain_all();

        // random phases over several cameras, with extreme matrices too
        load_camera(100, 320, 240, 640, 480);
        random_phase(250);
        hold_recv = 300;
        drain_all();
        load_camera(500, 32767, 32767, 65535, 65535);
        random_phase(200);
        drain_all();
        for (int i = 0; i < 6; i++)
            write_reg(IDX_BITS'(REG_ROW0_A + i), {$urandom, $urandom});
        write_reg(REG_IMAGE_SIZE, {32'd0, $urandom});
        random_phase(150);
        drain_all();
        write_reg(REG_ROW0_A, 64'h7fff_ffff_8000_0000);
        write_reg(IDX_BITS'(REG_ROW0_A + 4), 64'h8000_0000_7fff_ffff);
        write_reg(REG_IMAGE_SIZE, 64'hffff_ffff);
        random_phase(100);
        drain_all();
        write_reg(REG_CROP_ENABLE, 64'd0);
        random_phase(150);
        drain_all();
        write_reg(REG_CROP_ENABLE, 64'd1);
        load_camera(40, 80, 60, 160, 120);
        random_phase(200);
        hold_recv = 200;
        drain_all();
        calm = 1'b1;
        load_camera(100, 320, 240, 640, 480);
        random_phase(200);
        drain_all();

        $display("sent %0d points, %0d kept and checked, across pass-through and crop setups",
                 sent_total, kept_total);
        if (mismatches == 0)
            $display("[lidar_point_frustum_crop] OK");
        else
            $display("[lidar_point_frustum_crop] ERROR");
        $finish;
    end
endmodule
